/* rtl/cif_pkg.sv */
`default_nettype none

package cif_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int MASK_SIZE      = 3;
  localparam int WIN_EDGE       = MASK_SIZE - 1;
  localparam int NTAP           = MASK_SIZE * MASK_SIZE;
  localparam int DIVISOR        = 16;
  localparam int DIV_SHIFT      = $clog2(DIVISOR);

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = PIX_W + COEF_W + 1;
  localparam int SUM_W   = 20;
  localparam int MASK_W  = MASK_SIZE * COEF_W;
  localparam int LW_W    = 11;
  localparam int CNT_W   = $clog2(MAX_LINE_WIDTH);
  localparam int WID_W   = (LW_W > CNT_W + 1) ? LW_W : CNT_W + 1;
  localparam int MIN_LINE_WIDTH = 3;
  localparam int ADDR_W  = 3;
  localparam int CFG_W   = MASK_W;

  // line store word: older row in the upper byte, newer row in the lower byte
  localparam int LS_W    = 2 * PIX_W;

  localparam logic [LW_W-1:0] LW_RESET = LW_W'(1024);
  localparam logic [1:0]      ROW_FULL = 2'(WIN_EDGE);

  typedef enum logic [ADDR_W-1:0] {
    REG_MASK_TOP    = 3'd0,
    REG_MASK_MID    = 3'd1,
    REG_MASK_BOTTOM = 3'd2,
    REG_LINE_WIDTH  = 3'd3,
    REG_DIVIDE      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered;
    logic                    row_end;
  } pix_out_t;

  typedef struct packed {
    logic [MASK_SIZE-1:0][MASK_W-1:0] mask;
    logic [LW_W-1:0]                  line_width;
    logic                             divide_by_sixteen;
  } cfg_t;

  typedef struct packed {
    logic [MASK_SIZE-1:0][MASK_SIZE-1:0][PIX_W-1:0] pix;
    logic                                           last;
  } win_t;

endpackage

`default_nettype wire

/* rtl/cif_ram.sv */
`default_nettype none

module cif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cif_window.sv */
`default_nettype none

module cif_window
  import cif_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pix_in_t in_data,
  output logic         win_valid,
  input  wire logic    win_ready,
  output win_t         win_data
);

  logic [CNT_W-1:0] column_count_r, column_count_nxt;
  logic [1:0]       row_count_r, row_count_nxt;

  logic             s1_v_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CNT_W-1:0] s1_col_r;
  logic             s1_last_r;
  logic             s1_prod_r;
  logic             byp_v_r;
  logic [LS_W-1:0]  byp_data_r;
  logic [PIX_W-1:0] win_r [2*MASK_SIZE];

  logic [WID_W-1:0] lw_ext, wact;
  logic [CNT_W-1:0] last_col, cnt_sel, col_in;
  logic [1:0]       row_sel;
  logic             last_in, prod_in;
  logic             in_accept, s1_adv;
  logic [LS_W-1:0]  ram_q, ls_q, ls_wdata;
  logic [MASK_SIZE-1:0][MASK_SIZE-1:0][PIX_W-1:0] win;

  always_comb begin
    lw_ext = WID_W'(cfg.line_width);
    if (lw_ext < WID_W'(MIN_LINE_WIDTH)) begin
      wact = WID_W'(MIN_LINE_WIDTH);
    end else if (lw_ext > WID_W'(MAX_LINE_WIDTH)) begin
      wact = WID_W'(MAX_LINE_WIDTH);
    end else begin
      wact = lw_ext;
    end
    last_col = CNT_W'(wact - WID_W'(1));

    cnt_sel = in_data.frame_start ? '0 : column_count_r;
    row_sel = in_data.frame_start ? 2'd0 : row_count_r;
    // a count already past a narrowed width ends the row here
    col_in  = (cnt_sel >= last_col) ? last_col : cnt_sel;
    last_in = (col_in == last_col);
    prod_in = (row_sel == ROW_FULL) && (col_in >= CNT_W'(WIN_EDGE));

    if (last_in) begin
      column_count_nxt = '0;
      row_count_nxt    = (row_sel == ROW_FULL) ? row_sel : row_sel + 2'd1;
    end else begin
      column_count_nxt = col_in + CNT_W'(1);
      row_count_nxt    = row_sel;
    end
  end

  assign s1_adv    = s1_v_r && (!s1_prod_r || win_ready);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // previous pixel writes the entry this one reads in the same cycle
  assign ls_q     = byp_v_r ? byp_data_r : ram_q;
  assign ls_wdata = {ls_q[PIX_W-1:0], s1_px_r};

  cif_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (ls_wdata),
    .re    (in_accept),
    .raddr (col_in),
    .rdata (ram_q)
  );

  always_comb begin
    for (int r = 0; r < MASK_SIZE; r++) begin
      win[r][0] = win_r[r*2];
      win[r][1] = win_r[r*2+1];
    end
    win[0][2] = ls_q[LS_W-1:PIX_W];
    win[1][2] = ls_q[PIX_W-1:0];
    win[2][2] = s1_px_r;
  end

  assign win_valid     = s1_v_r && s1_prod_r;
  assign win_data.pix  = win;
  assign win_data.last = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      s1_v_r         <= 1'b0;
      byp_v_r        <= 1'b0;
      for (int i = 0; i < 2*MASK_SIZE; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        for (int r = 0; r < MASK_SIZE; r++) begin
          win_r[r*2]   <= win[r][1];
          win_r[r*2+1] <= win[r][2];
        end
      end
      if (in_accept) begin
        column_count_r <= column_count_nxt;
        row_count_r    <= row_count_nxt;
        byp_v_r        <= s1_adv && (s1_col_r == col_in);
        s1_v_r         <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r  <= 1'b0;
        byp_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= in_data.pixel;
      s1_col_r   <= col_in;
      s1_last_r  <= last_in;
      s1_prod_r  <= prod_in;
      byp_data_r <= ls_wdata;
    end
  end

`ifndef SYNTH
  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r != 2'd3)
    else $error("row count passed saturation");

  a_byp_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    byp_v_r |-> s1_v_r)
    else $error("line store bypass without a held pixel");

  a_prod_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_prod_r) |-> (s1_col_r >= CNT_W'(WIN_EDGE)))
    else $error("result requested for a border column");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_col_r) && $stable(s1_px_r)))
    else $error("held pixel changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/cif_mac.sv */
`default_nettype none

module cif_mac
  import cif_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic win_valid,
  output logic      win_ready,
  input  wire win_t win_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output pix_out_t  out_data
);

  logic                     s2_v_r;
  win_t                     s2_win_r;
  logic                     s3_v_r;
  logic signed [PROD_W-1:0] s3_prod_r [NTAP];
  logic signed [PROD_W-1:0] prod_nxt  [NTAP];
  logic                     s3_last_r;
  logic                     out_v_r;
  pix_out_t                 out_r, out_nxt;

  logic out_ready, s3_ready;
  logic signed [SUM_W-1:0] sum, sum_adj;

  assign out_ready = !out_v_r || !out_stall;
  assign s3_ready  = !s3_v_r || out_ready;
  assign win_ready = !s2_v_r || s3_ready;

  always_comb begin
    for (int r = 0; r < MASK_SIZE; r++) begin
      for (int c = 0; c < MASK_SIZE; c++) begin
        prod_nxt[r*MASK_SIZE+c] = PROD_W'($signed({1'b0, s2_win_r.pix[r][c]})
                                * $signed(cfg.mask[r][c*COEF_W +: COEF_W]));
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NTAP; i++) begin
      sum = sum + SUM_W'(s3_prod_r[i]);
    end
    // bias negative sums so the shift truncates toward zero
    sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(DIVISOR - 1) : SUM_W'(0));
    out_nxt.filtered = cfg.divide_by_sixteen ? (sum_adj >>> DIV_SHIFT) : sum;
    out_nxt.row_end  = s3_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (win_ready) begin
        s2_v_r <= win_valid;
      end
      if (s3_ready) begin
        s3_v_r <= s2_v_r;
      end
      if (out_ready) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_ready && win_valid) begin
      s2_win_r <= win_data;
    end
    if (s3_ready && s2_v_r) begin
      for (int i = 0; i < NTAP; i++) begin
        s3_prod_r[i] <= prod_nxt[i];
      end
      s3_last_r <= s2_win_r.last;
    end
    if (out_ready && s3_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* rtl/conv3x3_image_filter.sv */
// 3x3 convolution over an 8-bit raster pixel stream. One pixel is taken per
// clock, sustained while in_stall is low; the line store is a single RAM with
// one write and one read port, each used once per pixel, and that sets the
// rate. A result passes the pixel, window and product registers and the output
// register that holds the sum, and appears only for interior pixels: row two
// onward and column two onward, with row_end on the last column. frame_start
// restarts the row and column counts on its own pixel. Both previous rows share
// one 16-bit by MAX_LINE_WIDTH RAM; it needs no clearing pass since each entry
// is written before its contents reach a result. Mask registers hold three
// signed 8-bit coefficients, column 0 in the low byte; line_width is clamped
// to 3..MAX_LINE_WIDTH. Write configuration only while the block is empty.
`default_nettype none

module conv3x3_image_filter
  import cif_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pix_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pix_out_t               out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic win_valid, win_ready;
  win_t win_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask              <= '0;
      cfg_r.line_width        <= LW_RESET;
      cfg_r.divide_by_sixteen <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_MASK_TOP:    cfg_r.mask[0] <= cfg_data[MASK_W-1:0];
        REG_MASK_MID:    cfg_r.mask[1] <= cfg_data[MASK_W-1:0];
        REG_MASK_BOTTOM: cfg_r.mask[2] <= cfg_data[MASK_W-1:0];
        REG_LINE_WIDTH:  cfg_r.line_width <= cfg_data[LW_W-1:0];
        REG_DIVIDE:      cfg_r.divide_by_sixteen <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cif_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_data  (win_data)
  );

  cif_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_data  (win_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
